>>> hdl/filtered_sorted_topk_list_core_defines.svh
// ----------------------------------------------------------------------------
// filtered sorted top-k list: assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef FILTERED_SORTED_TOPK_LIST_CORE_DEFINES_SVH
`define FILTERED_SORTED_TOPK_LIST_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define FTK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ftk check failed");

// next-cycle implication, disabled while reset is low
`define FTK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ftk check failed");

`endif

>>> hdl/ftk_pkg.sv
// ----------------------------------------------------------------------------
// ftk_pkg
// widths, codes and shared types of the filtered sorted top-k list
// ----------------------------------------------------------------------------
package ftk_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int HARD_CAP       = 32;

    localparam int TAG_W   = 16;
    localparam int PRICE_W = 32;
    localparam int CTX_W   = 26;
    localparam int CNT_W   = 6;
    localparam int RANK_W  = 5;
    localparam int LIM_W   = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 26;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CTX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LIM = 1'd1;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 56;

    // request kinds carried in the request tuser bit
    typedef enum logic {
        REQ_OFFER = 1'b0,
        REQ_DUMP  = 1'b1
    } t_req_kind;

    typedef logic        [TAG_W-1:0]   t_tag;
    typedef logic signed [PRICE_W-1:0] t_price;

    // broadcast from the control to every cell of the chain
    typedef struct packed {
        logic             offer_en;
        logic             dump_shift;
        logic             count_lt_cap;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] cap;
        t_price           price;
        t_tag             tag;
    } t_cell_ctrl;

endpackage

>>> hdl/ftk_cell.sv
// ----------------------------------------------------------------------------
// ftk_cell
// one slot of the sorted chain: compare, insert, shift down or shift up
// ----------------------------------------------------------------------------
module ftk_cell
    import ftk_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_prev_hit,
    input  t_price     i_prev_price,
    input  t_tag       i_prev_tag,
    input  t_price     i_next_price,
    input  t_tag       i_next_tag,
    output logic       o_hit,
    output t_price     o_price,
    output t_tag       o_tag
);

    localparam logic [CNT_W:0] IDX = (CNT_W+1)'(CELL_IDX);

    t_price r_price, n_price;
    t_tag   r_tag, n_tag;

    logic [CNT_W:0] w_count;
    logic [CNT_W:0] w_cap;
    logic           w_in_rng;
    logic           w_ins;
    logic           w_shift;
    logic           w_below_last;

    assign w_count  = {1'b0, i_ctrl.count};
    assign w_cap    = {1'b0, i_ctrl.cap};
    assign w_in_rng = (IDX < w_count) && (IDX < w_cap);
    assign o_hit    = w_in_rng && (i_ctrl.price < r_price);

    // kept entries stay sorted, so hits form one run; its head takes the offer, else the fill point below the cap
    assign w_ins = i_ctrl.offer_en &&
                   ((o_hit && !i_prev_hit) ||
                    ((IDX == w_count) && i_ctrl.count_lt_cap && !i_prev_hit));

    // shifting stops at the fill point, or at the cap when full
    assign w_below_last = i_ctrl.count_lt_cap ? (IDX <= w_count) : (IDX < w_cap);
    assign w_shift      = i_ctrl.offer_en && i_prev_hit && w_below_last;

    always_comb begin
        n_price = r_price;
        n_tag   = r_tag;
        if (w_ins) begin
            n_price = i_ctrl.price;
            n_tag   = i_ctrl.tag;
        end else if (w_shift) begin
            n_price = i_prev_price;
            n_tag   = i_prev_tag;
        end else if (i_ctrl.dump_shift) begin
            n_price = i_next_price;
            n_tag   = i_next_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_price <= n_price;
        r_tag   <= n_tag;
    end

    assign o_price = r_price;
    assign o_tag   = r_tag;

endmodule

>>> hdl/filtered_sorted_topk_list_core.sv
// ----------------------------------------------------------------------------
// filtered_sorted_topk_list_core
// top-k candidate list kept sorted by ascending price in a chain of cells
// ----------------------------------------------------------------------------
// Offers pass a filter (tool capable, not excluded, context at least
// min_context unless that is zero, price not negative) and are placed in a
// chain of LIST_DEPTH cells: every cell compares the offered price with its
// own, the head of the run of higher prices takes the offer and the cells
// behind it take their left neighbor, so equal prices keep arrival order and
// the tail entry drops off when the list holds K = min(keep_limit, LIST_DEPTH,
// 32) entries. Offers are taken one per cycle back to back while no dump
// streams out. Once a dump request is accepted, the n kept entries stream out
// (a single result flagged empty when nothing is kept) while the chain shifts
// one entry into cell 0 per cycle toward the single output register; the
// stream slows with master-side backpressure, and no request is taken until the
// last result is loaded. After the dump the list is empty. Cell contents need
// no clearing pass at reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
`include "filtered_sorted_topk_list_core_defines.svh"

module filtered_sorted_topk_list_core
    import ftk_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // model_tag[15:0], has_tools[16], excluded[17], ctx_len[43:18],
    // price[75:44], zero fill up to bit 79
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[0]
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // entry_tag[15:0], entry_price[47:16], entry_rank[52:48], zero fill to bit 55
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // list_empty[0]
    output logic                  m_axis_tuser,
    // last result of a dump
    output logic                  m_axis_tlast
);

    localparam int CAP_MAX = (LIST_DEPTH < HARD_CAP) ? LIST_DEPTH : HARD_CAP;
    localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CAP_MAX);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    // configuration
    logic [CTX_W-1:0]  r_min_ctx;
    logic [LIM_W-1:0]  r_keep_lim;

    // control state
    logic              r_state,  n_state;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [CNT_W-1:0]  r_n,      n_n;
    logic [RANK_W-1:0] r_rank,   n_rank;

    // output register
    logic              r_ovalid, n_ovalid;
    t_tag              r_otag,   n_otag;
    t_price            r_oprice, n_oprice;
    logic [RANK_W-1:0] r_orank,  n_orank;
    logic              r_oempty, n_oempty;
    logic              r_olast,  n_olast;

    // request fields
    t_tag              w_tag;
    logic              w_tool;
    logic              w_excl;
    logic [CTX_W-1:0]  w_ctx;
    t_price            w_price;

    logic              w_accept;
    logic              w_pass;
    logic              w_offer_en;
    logic [CNT_W-1:0]  w_cap;
    logic              w_count_lt_cap;
    logic              w_load;
    logic              w_dump_last;
    logic              w_dump_shift;

    t_cell_ctrl        w_ctrl;

    logic              w_hit   [LIST_DEPTH];
    t_price            w_cprice[LIST_DEPTH];
    t_tag              w_ctag  [LIST_DEPTH];

    assign w_tag   = s_axis_tdata[15:0];
    assign w_tool  = s_axis_tdata[16];
    assign w_excl  = s_axis_tdata[17];
    assign w_ctx   = s_axis_tdata[43:18];
    assign w_price = s_axis_tdata[75:44];

    // requests are held off only while a dump streams out
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // candidate filter
    assign w_pass = w_tool && !w_excl && !w_price[PRICE_W-1] &&
                    !((r_min_ctx != '0) && (w_ctx < r_min_ctx));
    assign w_offer_en = w_accept && (s_axis_tuser == REQ_OFFER) && w_pass;

    // list size: keep_limit saturated at the chain length and the hard cap
    assign w_cap          = (r_keep_lim > CAP_LIM) ? CAP_LIM : r_keep_lim;
    assign w_count_lt_cap = (r_count < w_cap);

    // dump sequencing: one entry into the output register per free slot
    assign w_load       = (r_state == ST_DUMP) && (!r_ovalid || m_axis_tready);
    assign w_dump_last  = (({1'b0, r_rank} + 1'b1) == r_n);
    assign w_dump_shift = w_load && (r_n != '0);

    assign w_ctrl.offer_en     = w_offer_en;
    assign w_ctrl.dump_shift   = w_dump_shift;
    assign w_ctrl.count_lt_cap = w_count_lt_cap;
    assign w_ctrl.count        = r_count;
    assign w_ctrl.cap          = w_cap;
    assign w_ctrl.price        = w_price;
    assign w_ctrl.tag          = w_tag;

    // chain of cells: left neighbor feeds insertion shifts, right one feeds dumps
    for (genvar gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
        logic   w_prev_hit;
        t_price w_prev_price;
        t_tag   w_prev_tag;
        t_price w_next_price;
        t_tag   w_next_tag;

        if (gi == 0) begin : g_head
            assign w_prev_hit   = 1'b0;
            assign w_prev_price = w_price;
            assign w_prev_tag   = w_tag;
        end else begin : g_body
            assign w_prev_hit   = w_hit[gi-1];
            assign w_prev_price = w_cprice[gi-1];
            assign w_prev_tag   = w_ctag[gi-1];
        end

        if (gi == LIST_DEPTH - 1) begin : g_tail
            assign w_next_price = w_cprice[gi];
            assign w_next_tag   = w_ctag[gi];
        end else begin : g_mid
            assign w_next_price = w_cprice[gi+1];
            assign w_next_tag   = w_ctag[gi+1];
        end

        ftk_cell #(
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_prev_hit   (w_prev_hit),
            .i_prev_price (w_prev_price),
            .i_prev_tag   (w_prev_tag),
            .i_next_price (w_next_price),
            .i_next_tag   (w_next_tag),
            .o_hit        (w_hit[gi]),
            .o_price      (w_cprice[gi]),
            .o_tag        (w_ctag[gi])
        );
    end

    // next-state logic for control and the output register
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_rank   = r_rank;
        n_ovalid = r_ovalid;
        n_otag   = r_otag;
        n_oprice = r_oprice;
        n_orank  = r_orank;
        n_oempty = r_oempty;
        n_olast  = r_olast;

        if (r_ovalid && m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_offer_en && w_count_lt_cap) begin
                    n_count = r_count + 1'b1;
                end
                if (w_accept && (s_axis_tuser != REQ_OFFER)) begin
                    n_state = ST_DUMP;
                    n_n     = r_count;
                    n_rank  = '0;
                end
            end
            ST_DUMP: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    if (r_n == '0) begin
                        // nothing kept: a single flagged result
                        n_otag   = '0;
                        n_oprice = '0;
                        n_orank  = '0;
                        n_oempty = 1'b1;
                        n_olast  = 1'b1;
                        n_state  = ST_IDLE;
                        n_count  = '0;
                    end else begin
                        n_otag   = w_ctag[0];
                        n_oprice = w_cprice[0];
                        n_orank  = r_rank;
                        n_oempty = 1'b0;
                        n_olast  = w_dump_last;
                        if (w_dump_last) begin
                            n_state = ST_IDLE;
                            n_count = '0;
                        end else begin
                            n_rank = r_rank + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ctx  <= '0;
            r_keep_lim <= LIM_W'(HARD_CAP);
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_n        <= '0;
            r_rank     <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_CTX:  r_min_ctx  <= i_cfg_data[CTX_W-1:0];
                    CFG_KEEP_LIM: r_keep_lim <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_rank   <= n_rank;
            r_ovalid <= n_ovalid;
        end
    end

    // payload of the output register, no reset
    always_ff @(posedge i_clk) begin
        r_otag   <= n_otag;
        r_oprice <= n_oprice;
        r_orank  <= n_orank;
        r_oempty <= n_oempty;
        r_olast  <= n_olast;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {3'b000, r_orank, r_oprice, r_otag};
    assign m_axis_tuser  = r_oempty;
    assign m_axis_tlast  = r_olast;

    // fill count never passes the largest list size
    `FTK_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CAP_LIM)
    // an accepted dump starts streaming from rank zero with the count captured
    `FTK_ASSERT_NXT(a_dump_start, w_accept && (s_axis_tuser != REQ_OFFER),
                    (r_state == ST_DUMP) && (r_rank == '0))
    // the empty marker only ever comes as the single, final result
    `FTK_ASSERT_IMP(a_empty_last, r_ovalid && r_oempty, r_olast && (r_orank == '0))
    // loading the final result of a dump leaves the list empty and idle
    `FTK_ASSERT_NXT(a_dump_clears, w_load && ((r_n == '0) || w_dump_last),
                    (r_count == '0) && (r_state == ST_IDLE))

endmodule
